// ===== src/tds_pkg.sv =====
// ----------------------------------------------------------------------------
// tds_pkg
// shared types, constants and fixed-point helpers of the tridiagonal solver
// ----------------------------------------------------------------------------
package tds_pkg;

	localparam int MAX_ROWS  = 64;
	localparam int IDX_W     = $clog2(MAX_ROWS);
	localparam int CNT_W     = IDX_W + 1;
	localparam int Q_DEPTH   = 2;
	localparam int Q_PTR_W   = (Q_DEPTH > 1) ? $clog2(Q_DEPTH) : 1;
	localparam int Q_CNT_W   = $clog2(Q_DEPTH + 1);
	localparam int DIV_RADIX_BITS = 2;
	localparam int DIV_DVD_W = 48;
	localparam int DIV_STEPS = DIV_DVD_W / DIV_RADIX_BITS;
	localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

	localparam logic signed [31:0] Q_MAX = 32'sh7fffffff;
	localparam logic signed [31:0] Q_MIN = 32'sh80000000;
	localparam logic signed [63:0] W_MAX = 64'sd2147483647;
	localparam logic signed [63:0] W_MIN = -64'sd2147483648;

	// one row word after classification by the front end
	typedef struct packed {
		logic signed [31:0] sub_diag;
		logic signed [31:0] main_diag;
		logic signed [31:0] super_diag;
		logic signed [31:0] rhs;
		logic               last_row;
		logic [IDX_W-1:0]   idx;
		logic               first;
		logic               over;
	} row_t;

	typedef struct packed {
		logic               start;
		logic signed [31:0] num;
		logic signed [31:0] den;
	} div_req_t;

	typedef struct packed {
		logic               done;
		logic               busy;
		logic signed [31:0] quo;
		logic               ovf;
	} div_rsp_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_EDIV,
		ST_EMUL1,
		ST_EMUL2,
		ST_ESUB,
		ST_BSTART,
		ST_BDIV,
		ST_BOUT,
		ST_BRD,
		ST_BMUL,
		ST_BSUB,
		ST_BDST
	} back_state_t;

	// saturate to 32 bits, msb of result is the overflow flag
	function automatic logic [32:0] sat_to_q(input logic signed [63:0] v);
		logic [32:0] res;
		if (v > W_MAX) begin
			res = {1'b1, Q_MAX};
		end else if (v < W_MIN) begin
			res = {1'b1, Q_MIN};
		end else begin
			res = {1'b0, v[31:0]};
		end
		return res;
	endfunction

	// q16.16 product rescale, truncating toward zero
	function automatic logic [32:0] qscale(input logic signed [63:0] p);
		logic signed [63:0] s;
		s = p >>> 16;
		if (p[63] && (p[15:0] != 16'd0)) begin
			s = s + 64'sd1;
		end
		return sat_to_q(s);
	endfunction

	function automatic logic [32:0] sub_sat(input logic signed [31:0] a,
		input logic signed [31:0] b);
		logic signed [63:0] d;
		d = 64'(a) - 64'(b);
		return sat_to_q(d);
	endfunction

endpackage

// ===== src/tds_front.sv =====
// ----------------------------------------------------------------------------
// tds_front
// accepts row words, numbers them and flags first and overflow rows
// ----------------------------------------------------------------------------
module tds_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sub_diag,
	input  logic signed [31:0] main_diag,
	input  logic signed [31:0] super_diag,
	input  logic signed [31:0] rhs,
	input  logic               last_row,
	input  logic               q_full,
	output logic               push,
	output tds_pkg::row_t      item
);
	import tds_pkg::*;

	logic [CNT_W-1:0] cnt_q;
	logic             over;

	assign in_stall = q_full;
	assign push     = in_valid && !q_full;
	assign over     = (cnt_q == CNT_W'(MAX_ROWS));

	always_comb begin
		item.sub_diag   = sub_diag;
		item.main_diag  = main_diag;
		item.super_diag = super_diag;
		item.rhs        = rhs;
		item.last_row   = last_row;
		item.idx        = cnt_q[IDX_W-1:0];
		item.first      = (cnt_q == '0);
		item.over       = over;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (push) begin
			if (last_row) begin
				cnt_q <= '0;
			end else if (!over) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
		end
	end

endmodule

// ===== src/tds_queue.sv =====
// ----------------------------------------------------------------------------
// tds_queue
// short fifo of classified rows between front and back end
// ----------------------------------------------------------------------------
module tds_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  tds_pkg::row_t push_item,
	output logic          full,
	input  logic          pop,
	output logic          not_empty,
	output tds_pkg::row_t head
);
	import tds_pkg::*;

	row_t               slot_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_q;
	logic [Q_PTR_W-1:0] rd_q;
	logic [Q_CNT_W-1:0] cnt_q;
	logic               do_pop;

	assign full      = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign not_empty = (cnt_q != '0);
	assign head      = slot_q[rd_q];
	assign do_pop    = pop && not_empty;

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (wr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_q + Q_PTR_W'(1);
			end
			if (do_pop) begin
				rd_q <= (rd_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_q + Q_PTR_W'(1);
			end
			unique case ({push, do_pop})
				2'b10:   cnt_q <= cnt_q + Q_CNT_W'(1);
				2'b01:   cnt_q <= cnt_q - Q_CNT_W'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	a_no_overfill: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= Q_CNT_W'(Q_DEPTH)) else $error("queue count beyond depth");

endmodule

// ===== src/tds_div.sv =====
// ----------------------------------------------------------------------------
// tds_div
// iterative q16.16 divider, two quotient bits a cycle, saturating
// ----------------------------------------------------------------------------
module tds_div (
	input  logic               clk,
	input  logic               arst_n,
	input  tds_pkg::div_req_t  req,
	output tds_pkg::div_rsp_t  rsp
);
	import tds_pkg::*;

	logic                 busy_q;
	logic                 done_q;
	logic [DIV_CNT_W-1:0] cnt_q;
	logic [31:0]          rem_q;
	logic [DIV_DVD_W-1:0] dvd_q;
	logic [31:0]          dmag_q;
	logic                 neg_q;
	logic signed [31:0]   quo_q;
	logic                 ovf_q;

	logic [31:0]          rem_n;
	logic [DIV_DVD_W-1:0] dvd_n;
	logic [32:0]          trial;
	logic [31:0]          nmag;
	logic [31:0]          dmag;

	assign nmag = req.num[31] ? (~req.num + 32'd1) : req.num;
	assign dmag = req.den[31] ? (~req.den + 32'd1) : req.den;

	// restoring steps
	always_comb begin
		rem_n = rem_q;
		dvd_n = dvd_q;
		trial = '0;
		for (int k = 0; k < DIV_RADIX_BITS; k++) begin
			trial = {rem_n, dvd_n[DIV_DVD_W-1]};
			dvd_n = {dvd_n[DIV_DVD_W-2:0], 1'b0};
			if (trial >= {1'b0, dmag_q}) begin
				trial    = trial - {1'b0, dmag_q};
				dvd_n[0] = 1'b1;
			end
			rem_n = trial[31:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				if (req.den == '0) begin
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= DIV_CNT_W'(DIV_STEPS);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - DIV_CNT_W'(1);
				if (cnt_q == DIV_CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q  <= '0;
			dvd_q  <= {nmag, 16'd0};
			dmag_q <= dmag;
			neg_q  <= req.num[31] ^ req.den[31];
			if (req.den == '0) begin
				quo_q <= req.num[31] ? Q_MIN : Q_MAX;
				ovf_q <= 1'b1;
			end
		end else if (busy_q) begin
			rem_q <= rem_n;
			dvd_q <= dvd_n;
			if (cnt_q == DIV_CNT_W'(1)) begin
				if (neg_q) begin
					if (dvd_n > DIV_DVD_W'(33'h080000000)) begin
						quo_q <= Q_MIN;
						ovf_q <= 1'b1;
					end else begin
						quo_q <= ~dvd_n[31:0] + 32'd1;
						ovf_q <= 1'b0;
					end
				end else begin
					if (dvd_n > DIV_DVD_W'(33'h07fffffff)) begin
						quo_q <= Q_MAX;
						ovf_q <= 1'b1;
					end else begin
						quo_q <= dvd_n[31:0];
						ovf_q <= 1'b0;
					end
				end
			end
		end
	end

	always_comb begin
		rsp.done = done_q;
		rsp.busy = busy_q;
		rsp.quo  = quo_q;
		rsp.ovf  = ovf_q;
	end

	a_no_restart: assert property (@(posedge clk) disable iff (!arst_n)
		req.start |-> !busy_q) else $error("divider started while busy");

endmodule

// ===== src/tds_back.sv =====
// ----------------------------------------------------------------------------
// tds_back
// forward elimination and back substitution sequencer with row stores
// ----------------------------------------------------------------------------
module tds_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_valid,
	input  tds_pkg::row_t      q_item,
	output logic               pop,
	output tds_pkg::div_req_t  dreq,
	input  tds_pkg::div_rsp_t  drsp,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] solution,
	output logic [5:0]         row_index,
	output logic               last_result,
	output logic               error
);
	import tds_pkg::*;

	back_state_t state_q, state_d;

	logic signed [31:0] piv_mem [MAX_ROWS];
	logic signed [31:0] rhs_mem [MAX_ROWS];
	logic signed [31:0] up_mem  [MAX_ROWS];

	row_t               cur_q;
	logic signed [31:0] m_q;
	logic signed [63:0] prod_s1;
	logic signed [31:0] piv_new_q;
	logic signed [31:0] prev_piv_q, prev_rhs_q, prev_up_q;
	logic [IDX_W-1:0]   top_q, i_q;
	logic signed [31:0] x_q, t_q;
	logic signed [31:0] rd_piv_q, rd_rhs_q, rd_up_q;
	logic               err_q;

	logic               out_valid_q;
	logic signed [31:0] out_sol_q;
	logic [5:0]         out_idx_q;
	logic               out_last_q;
	logic               out_err_q;

	logic               out_free, out_load;
	logic               mem_we;
	logic [IDX_W-1:0]   mem_addr;
	logic signed [31:0] wr_piv, wr_rhs, wr_up;
	logic signed [31:0] mul_a, mul_b;
	logic signed [63:0] mul_p;
	logic signed [31:0] sub_a;
	logic [32:0]        sc_w, dif_w;

	assign out_free = !out_valid_q || !out_stall;

	// shared multiplier and rescale/subtract path
	always_comb begin
		unique case (state_q)
			ST_EMUL2: begin mul_a = m_q;     mul_b = prev_rhs_q; end
			ST_BMUL:  begin mul_a = rd_up_q; mul_b = x_q;        end
			default:  begin mul_a = m_q;     mul_b = prev_up_q;  end
		endcase
		mul_p = mul_a * mul_b;
		unique case (state_q)
			ST_EMUL2: sub_a = cur_q.main_diag;
			ST_ESUB:  sub_a = cur_q.rhs;
			default:  sub_a = rd_rhs_q;
		endcase
		sc_w  = qscale(prod_s1);
		dif_w = sub_sat(sub_a, sc_w[31:0]);
	end

	// next state and control
	always_comb begin
		state_d  = state_q;
		pop      = 1'b0;
		dreq     = '0;
		out_load = 1'b0;
		mem_we   = 1'b0;
		mem_addr = cur_q.idx;
		wr_piv   = piv_new_q;
		wr_rhs   = dif_w[31:0];
		wr_up    = cur_q.super_diag;
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					pop = 1'b1;
					if (q_item.over || q_item.first) begin
						state_d = q_item.last_row ? ST_BSTART : ST_IDLE;
						if (q_item.first) begin
							mem_we   = 1'b1;
							mem_addr = q_item.idx;
							wr_piv   = q_item.main_diag;
							wr_rhs   = q_item.rhs;
							wr_up    = q_item.super_diag;
						end
					end else begin
						dreq.start = 1'b1;
						dreq.num   = q_item.sub_diag;
						dreq.den   = prev_piv_q;
						state_d    = ST_EDIV;
					end
				end
			end
			ST_EDIV:  if (drsp.done) state_d = ST_EMUL1;
			ST_EMUL1: state_d = ST_EMUL2;
			ST_EMUL2: state_d = ST_ESUB;
			ST_ESUB: begin
				mem_we  = 1'b1;
				state_d = cur_q.last_row ? ST_BSTART : ST_IDLE;
			end
			ST_BSTART: begin
				dreq.start = 1'b1;
				dreq.num   = prev_rhs_q;
				dreq.den   = prev_piv_q;
				state_d    = ST_BDIV;
			end
			ST_BDIV: if (drsp.done) state_d = ST_BOUT;
			ST_BOUT: begin
				if (out_free) begin
					out_load = 1'b1;
					state_d  = (i_q == '0) ? ST_IDLE : ST_BRD;
				end
			end
			ST_BRD:  state_d = ST_BMUL;
			ST_BMUL: state_d = ST_BSUB;
			ST_BSUB: state_d = ST_BDST;
			ST_BDST: begin
				dreq.start = 1'b1;
				dreq.num   = t_q;
				dreq.den   = rd_piv_q;
				state_d    = ST_BDIV;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// row stores
	always_ff @(posedge clk) begin
		if (mem_we) begin
			piv_mem[mem_addr] <= wr_piv;
			rhs_mem[mem_addr] <= wr_rhs;
			up_mem[mem_addr]  <= wr_up;
		end
		rd_piv_q <= piv_mem[i_q];
		rd_rhs_q <= rhs_mem[i_q];
		rd_up_q  <= up_mem[i_q];
	end

	// datapath
	always_ff @(posedge clk) begin
		unique case (state_q)
			ST_IDLE: begin
				if (q_valid) begin
					cur_q <= q_item;
					if (q_item.first) begin
						prev_piv_q <= q_item.main_diag;
						prev_rhs_q <= q_item.rhs;
						prev_up_q  <= q_item.super_diag;
						top_q      <= q_item.idx;
					end
				end
			end
			ST_EDIV:  if (drsp.done) m_q <= drsp.quo;
			ST_EMUL1: prod_s1 <= mul_p;
			ST_EMUL2: begin
				piv_new_q <= dif_w[31:0];
				prod_s1   <= mul_p;
			end
			ST_ESUB: begin
				prev_piv_q <= piv_new_q;
				prev_rhs_q <= dif_w[31:0];
				prev_up_q  <= cur_q.super_diag;
				top_q      <= cur_q.idx;
			end
			ST_BSTART: i_q <= top_q;
			ST_BDIV:   if (drsp.done) x_q <= drsp.quo;
			ST_BOUT:   if (out_free && (i_q != '0)) i_q <= i_q - IDX_W'(1);
			ST_BMUL:   prod_s1 <= mul_p;
			ST_BSUB:   t_q <= dif_w[31:0];
			default:   ;
		endcase
		if (out_load) begin
			out_sol_q  <= x_q;
			out_idx_q  <= 6'(i_q);
			out_last_q <= (i_q == '0);
			out_err_q  <= err_q;
		end
	end

	// sticky error of the system and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			err_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (q_valid && q_item.over) err_q <= 1'b1;
				ST_EDIV, ST_BDIV: if (drsp.done && drsp.ovf) err_q <= 1'b1;
				ST_EMUL2, ST_ESUB, ST_BSUB: if (sc_w[32] || dif_w[32]) err_q <= 1'b1;
				ST_BOUT:  if (out_load && (i_q == '0)) err_q <= 1'b0;
				default:  ;
			endcase
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid   = out_valid_q;
	assign solution    = out_sol_q;
	assign row_index   = out_idx_q;
	assign last_result = out_last_q;
	assign error       = out_err_q;

	a_last_is_row0: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_last_q |-> out_idx_q == 6'd0)
		else $error("final word not row zero");

	a_err_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		out_load && (i_q == '0) |=> !err_q)
		else $error("error flag not cleared after system");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		out_load |-> out_free) else $error("output word overwritten");

endmodule

// ===== src/tridiagonal_solver_top.sv =====
// ----------------------------------------------------------------------------
// tridiagonal_solver_top
// thomas algorithm tridiagonal solver, signed q16.16
// ----------------------------------------------------------------------------
//  channel  handshake            payload
//  in       in_valid / in_stall  sub_diag, main_diag, super_diag, rhs, last_row
//  out      out_valid/out_stall  solution, row_index, last_result, error
//
//  each row after the first passes through the back end as one pop, a divider
//  run of 24 steps of two quotient bits with a registered done, and three
//  multiply and subtract states; row zero is only popped and stored
//  each solution word likewise takes a divider run and read, multiply and subtract states
//  the front end and a two-word queue take rows while the back end works
//  arst_n clears control state only, the row stores need no clearing
//  a stalled output word holds and the back end waits for it to drain
// ----------------------------------------------------------------------------
module tridiagonal_solver_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  logic signed [31:0] sub_diag,
	input  logic signed [31:0] main_diag,
	input  logic signed [31:0] super_diag,
	input  logic signed [31:0] rhs,
	input  logic               last_row,
	output logic               out_valid,
	input  logic               out_stall,
	output logic signed [31:0] solution,
	output logic [5:0]         row_index,
	output logic               last_result,
	output logic               error
);
	import tds_pkg::*;

	// front to queue
	logic     push;
	row_t     push_item;
	logic     q_full;
	// queue to back end
	logic     q_valid;
	logic     pop;
	row_t     head;
	// back end to divider
	div_req_t dreq;
	div_rsp_t drsp;

	// numbers rows and marks first row and rows past capacity
	tds_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.sub_diag   (sub_diag),
		.main_diag  (main_diag),
		.super_diag (super_diag),
		.rhs        (rhs),
		.last_row   (last_row),
		.q_full     (q_full),
		.push       (push),
		.item       (push_item)
	);

	// decouples front from back end
	tds_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.full      (q_full),
		.pop       (pop),
		.not_empty (q_valid),
		.head      (head)
	);

	// elimination, row stores and back substitution
	tds_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_item      (head),
		.pop         (pop),
		.dreq        (dreq),
		.drsp        (drsp),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.solution    (solution),
		.row_index   (row_index),
		.last_result (last_result),
		.error       (error)
	);

	// shared by pivot quotient and solution quotient
	tds_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (dreq),
		.rsp    (drsp)
	);

endmodule
